// ===== rtl/tdc_pkg.sv =====
`timescale 1ns / 1ps

package tdc_pkg;

   localparam int DataWidth = 64;
   localparam int AddOps    = 3;   // operands still waiting behind the accumulator
   localparam int CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_COEFF_MODULUS   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SCALE_DELTA     = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_UPPER_INCREMENT = 2'd2;

   typedef logic [DataWidth-1:0] word_type;

   // accumulator plus the addends that later cells still have to fold in
   typedef struct packed {
      word_type                   acc;
      logic [AddOps-1:0][DataWidth-1:0] pend;
   } add_data_type;

   // partial remainder and the dividend word that turns into the quotient
   typedef struct packed {
      word_type rem;
      word_type word;
   } div_data_type;

endpackage

// ===== rtl/tdc_add_cell.sv =====
`timescale 1ns / 1ps

module tdc_add_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tdc_pkg::add_data_type in_data,
   input  tdc_pkg::word_type     modulus,
   input  tdc_pkg::word_type     fill,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tdc_pkg::add_data_type out_data
);

   logic                  valid_ff;
   tdc_pkg::add_data_type data_ff;
   tdc_pkg::add_data_type data_in;
   logic [tdc_pkg::DataWidth:0] sum;
   logic                  wrap;

   // acc + next addend, one conditional subtraction of q
   always_comb begin
      sum  = {1'b0, in_data.acc} + {1'b0, in_data.pend[tdc_pkg::AddOps-1]};
      wrap = sum[tdc_pkg::DataWidth] || (sum[tdc_pkg::DataWidth-1:0] >= modulus);
      data_in.acc  = wrap ? (sum[tdc_pkg::DataWidth-1:0] - modulus)
                          : sum[tdc_pkg::DataWidth-1:0];
      data_in.pend = {in_data.pend[tdc_pkg::AddOps-2:0], fill};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/tdc_div_cell.sv =====
`timescale 1ns / 1ps

module tdc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tdc_pkg::div_data_type in_data,
   input  tdc_pkg::word_type     divisor,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tdc_pkg::div_data_type out_data
);

   logic                  valid_ff;
   tdc_pkg::div_data_type data_ff;
   tdc_pkg::div_data_type data_in;
   logic [tdc_pkg::DataWidth:0] trial;
   logic [tdc_pkg::DataWidth:0] diff;
   logic                  qbit;

   // one restoring step: bring down the top dividend bit, try subtracting
   always_comb begin
      trial = {in_data.rem, in_data.word[tdc_pkg::DataWidth-1]};
      diff  = trial - {1'b0, divisor};
      qbit  = (trial >= {1'b0, divisor});
      data_in.rem  = qbit ? diff[tdc_pkg::DataWidth-1:0] : trial[tdc_pkg::DataWidth-1:0];
      data_in.word = {in_data.word[tdc_pkg::DataWidth-2:0], qbit};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/fv_threshold_decrypt_combine_round_top.sv =====
`timescale 1ns / 1ps

// Combines one coefficient of threshold FV/BFV decryption shares and rounds it
// to the plaintext coefficient. A request carries four residues mod q; they are
// summed mod q, floor(delta/2) is added mod q, values at or above ceil(q/2) get
// upper_increment subtracted, and the result is divided by delta (delta of zero
// yields all ones). It takes one request per cycle unless responses stall. The
// path has four modular-add cells, one rounding stage and 64 restoring-divider
// cells, one quotient bit per cell, the last of which is the response register.
// A cell stalls only when it and every cell after it are full, so empty cells
// keep accepting while a response waits. Configuration writes are always ready
// and must only be issued while no request is in flight.

module fv_threshold_decrypt_combine_round_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [63:0]                        req_dot_coeff,
   input  logic [63:0]                        req_c0_coeff,
   input  logic [63:0]                        req_partial_coeff,
   input  logic [63:0]                        req_noise_coeff,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [63:0]                        rsp_plain_coeff,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tdc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [63:0]                        csr_data
);

   localparam int NumAdd = tdc_pkg::AddOps + 1;
   localparam int NumDiv = tdc_pkg::DataWidth;

   // ---------------- configuration registers ----------------
   tdc_pkg::word_type modulus_ff;
   tdc_pkg::word_type delta_ff;
   tdc_pkg::word_type increment_ff;
   tdc_pkg::word_type half_delta;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= 64'd2;
         delta_ff     <= 64'd1;
         increment_ff <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tdc_pkg::CSR_COEFF_MODULUS:   modulus_ff   <= csr_data;
            tdc_pkg::CSR_SCALE_DELTA:     delta_ff     <= csr_data;
            tdc_pkg::CSR_UPPER_INCREMENT: increment_ff <= csr_data;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   assign half_delta = delta_ff >> 1;

   // ---------------- modular-add cells ----------------
   // Cell k folds in one addend; the pending list shifts and half_delta is
   // pushed in behind, so the last cell adds floor(delta/2).
   logic                  add_valid [NumAdd+1];
   logic                  add_ready [NumAdd+1];
   tdc_pkg::add_data_type add_data  [NumAdd+1];

   assign add_valid[0]     = req_valid;
   assign req_stall        = !add_ready[0];
   assign add_data[0].acc  = req_dot_coeff;
   assign add_data[0].pend = {req_c0_coeff, req_partial_coeff, req_noise_coeff};

   for (genvar k = 0; k < NumAdd; k++) begin : g_add
      tdc_add_cell u_add (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (add_valid[k]),
         .in_ready  (add_ready[k]),
         .in_data   (add_data[k]),
         .modulus   (modulus_ff),
         .fill      (half_delta),
         .out_valid (add_valid[k+1]),
         .out_ready (add_ready[k+1]),
         .out_data  (add_data[k+1])
      );
   end

   // ---------------- rounding stage ----------------
   // upper half of [0, q) is shifted down by q - t*delta before dividing
   logic              rnd_valid_ff;
   logic              rnd_ready;
   tdc_pkg::word_type rnd_value_ff;
   tdc_pkg::word_type rnd_value_in;
   tdc_pkg::word_type threshold;
   tdc_pkg::word_type acc_final;

   assign acc_final = add_data[NumAdd].acc;
   assign threshold = (modulus_ff >> 1) + {{(tdc_pkg::DataWidth-1){1'b0}}, modulus_ff[0]};
   assign rnd_value_in = (acc_final >= threshold) ? (acc_final - increment_ff) : acc_final;

   assign add_ready[NumAdd] = !rnd_valid_ff || rnd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (add_ready[NumAdd]) begin
         rnd_valid_ff <= add_valid[NumAdd];
      end
   end

   always_ff @(posedge clock) begin
      if (add_ready[NumAdd] && add_valid[NumAdd]) begin
         rnd_value_ff <= rnd_value_in;
      end
   end

   // ---------------- divider cells ----------------
   logic                  div_valid [NumDiv+1];
   logic                  div_ready [NumDiv+1];
   tdc_pkg::div_data_type div_data  [NumDiv+1];

   assign div_valid[0]     = rnd_valid_ff;
   assign rnd_ready        = div_ready[0];
   assign div_data[0].rem  = '0;
   assign div_data[0].word = rnd_value_ff;

   for (genvar k = 0; k < NumDiv; k++) begin : g_div
      tdc_div_cell u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .divisor   (delta_ff),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   // last divider cell doubles as the response register
   assign rsp_valid         = div_valid[NumDiv];
   assign div_ready[NumDiv] = !rsp_stall;
   assign rsp_plain_coeff   = div_data[NumDiv].word;

endmodule

// ===== rtl/tdc_checker.sv =====
`timescale 1ns / 1ps

module tdc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [63:0]                       rsp_plain_coeff,
   input logic                              csr_valid,
   input logic                              csr_ready
);

   // a stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_plain_coeff))
      else $error("stalled response changed");

   // requests back up only when the whole cell row is full behind a held response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while the pipeline has room");

   // reset empties the pipeline
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // configuration writes never wait
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write held off");

endmodule

bind fv_threshold_decrypt_combine_round_top tdc_checker u_tdc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_plain_coeff (rsp_plain_coeff),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready)
);

// ===== sim/tdc_checker.sv =====
`timescale 1ns / 1ps

module tdc_scoreboard (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [63:0]                       req_dot_coeff,
   input  logic [63:0]                       req_c0_coeff,
   input  logic [63:0]                       req_partial_coeff,
   input  logic [63:0]                       req_noise_coeff,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [63:0]                       rsp_plain_coeff,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [tdc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [63:0]                       csr_data,
   output int                                fail_count,
   output int                                pending
);

   tdc_pkg::word_type modulus_reg;
   tdc_pkg::word_type delta_reg;
   tdc_pkg::word_type incr_reg;
   tdc_pkg::word_type expected_plain_q[$];
   int                errors = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // 65-bit sum, one conditional subtraction of q on carry or sum >= q
   function automatic tdc_pkg::word_type add_mod(input tdc_pkg::word_type a,
                                                 input tdc_pkg::word_type b);
      logic [tdc_pkg::DataWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[tdc_pkg::DataWidth] || s[tdc_pkg::DataWidth-1:0] >= modulus_reg) begin
         return s[tdc_pkg::DataWidth-1:0] - modulus_reg;
      end
      return s[tdc_pkg::DataWidth-1:0];
   endfunction

   function automatic tdc_pkg::word_type round_to_plain(input tdc_pkg::word_type dot,
                                                        input tdc_pkg::word_type c0,
                                                        input tdc_pkg::word_type part,
                                                        input tdc_pkg::word_type noise);
      tdc_pkg::word_type v;
      tdc_pkg::word_type half_q;
      half_q = (modulus_reg >> 1) + tdc_pkg::word_type'(modulus_reg[0]);
      v = add_mod(dot, c0);
      v = add_mod(v, part);
      v = add_mod(v, noise);
      v = add_mod(v, delta_reg >> 1);
      if (v >= half_q) begin
         v = v - incr_reg;
      end
      if (delta_reg == '0) begin
         return '1;
      end
      return v / delta_reg;
   endfunction

   always @(posedge clock) begin
      tdc_pkg::word_type want;
      if (reset) begin
         modulus_reg = 64'd2;
         delta_reg   = 64'd1;
         incr_reg    = 64'd0;
         expected_plain_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tdc_pkg::CSR_COEFF_MODULUS:   modulus_reg = csr_data;
               tdc_pkg::CSR_SCALE_DELTA:     delta_reg   = csr_data;
               tdc_pkg::CSR_UPPER_INCREMENT: incr_reg    = csr_data;
               default: ;
            endcase
         end
         // pop before push: a response never belongs to a request of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_plain_q.size() == 0) begin
               report_mismatch($sformatf("response %h with no request pending",
                                         rsp_plain_coeff));
            end else begin
               want = expected_plain_q.pop_front();
               if (rsp_plain_coeff !== want) begin
                  report_mismatch($sformatf("plain_coeff %h, expected %h",
                                            rsp_plain_coeff, want));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_plain_q.push_back(round_to_plain(req_dot_coeff, req_c0_coeff,
                                                      req_partial_coeff, req_noise_coeff));
         end
      end
      fail_count <= errors;
      pending    <= expected_plain_q.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int QuietLimit = 3000;   // cycles with no handshake on any channel
   localparam int TotalItems = 1700;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BURST
   } stall_mode_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [63:0]                       req_dot_coeff = '0;
   logic [63:0]                       req_c0_coeff = '0;
   logic [63:0]                       req_partial_coeff = '0;
   logic [63:0]                       req_noise_coeff = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [63:0]                       rsp_plain_coeff;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [tdc_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [63:0]                       csr_data = '0;

   int                fail_count;
   int                pending;
   int                burst_left = 0;
   int                sent = 0;
   int                quiet_cycles = 0;
   tdc_pkg::word_type cur_q = 64'd2;      // modulus in force, steers the residue generator
   stall_mode_type    stall_mode = STALL_NONE;
   int                mode_cycles = 0;
   int                hold = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fv_threshold_decrypt_combine_round_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dot_coeff     (req_dot_coeff),
      .req_c0_coeff      (req_c0_coeff),
      .req_partial_coeff (req_partial_coeff),
      .req_noise_coeff   (req_noise_coeff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_plain_coeff   (rsp_plain_coeff),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   tdc_scoreboard u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dot_coeff     (req_dot_coeff),
      .req_c0_coeff      (req_c0_coeff),
      .req_partial_coeff (req_partial_coeff),
      .req_noise_coeff   (req_noise_coeff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_plain_coeff   (rsp_plain_coeff),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // Response side: the stall pattern switches mode whenever its random mode count runs out,
   // from no back-pressure at all through light and heavy random stalls to
   // long solid stalls that let the pipeline fill up behind the output.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         mode_cycles <= 0;
         hold        <= 0;
      end else begin
         if (mode_cycles == 0) begin
            stall_mode  <= stall_mode_type'($urandom_range(0, 3));
            mode_cycles <= $urandom_range(50, 400);
         end else begin
            mode_cycles <= mode_cycles - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: begin
               if (hold != 0) begin
                  hold      <= hold - 1;
                  rsp_stall <= 1'b1;
               end else if ($urandom_range(0, 7) == 0) begin
                  hold      <= $urandom_range(1, 30);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic tdc_pkg::word_type rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly reduced residues mod q, with edge values and unreduced words mixed in.
   function automatic tdc_pkg::word_type pick_field(input tdc_pkg::word_type q);
      tdc_pkg::word_type r;
      r = rand_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return q - 64'd1;                  // q of zero gives all ones
         2:       return '1;
         3, 4:    return r;
         5:       return (q > 64'd32) ? q - 64'($urandom_range(1, 32)) : r;  // small negative
         default: return (q == '0) ? r : r % q;
      endcase
   endfunction

   // delta = q div t, increment = q - t*delta
   task automatic derive(input tdc_pkg::word_type q, input tdc_pkg::word_type t,
                         output tdc_pkg::word_type d, output tdc_pkg::word_type inc);
      d   = q / t;
      inc = q - t * d;
   endtask

   // Drop valid and wait until every request has come back. Waiting for the
   // next edge first lets the pending count see a request accepted at this edge.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input tdc_pkg::word_type q, input tdc_pkg::word_type d,
                             input tdc_pkg::word_type inc);
      tdc_pkg::word_type                 vals[3];
      logic [tdc_pkg::CsrIndexWidth-1:0] idx[3];
      vals[0] = q;
      vals[1] = d;
      vals[2] = inc;
      idx[0]  = tdc_pkg::CSR_COEFF_MODULUS;
      idx[1]  = tdc_pkg::CSR_SCALE_DELTA;
      idx[2]  = tdc_pkg::CSR_UPPER_INCREMENT;
      drain();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cur_q = q;
   endtask

   // Sender works in bursts; a gap of zero keeps valid high across bursts.
   task automatic send_coeffs(input tdc_pkg::word_type dot, input tdc_pkg::word_type c0,
                              input tdc_pkg::word_type part, input tdc_pkg::word_type noise);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      req_valid         <= 1'b1;
      req_dot_coeff     <= dot;
      req_c0_coeff      <= c0;
      req_partial_coeff <= part;
      req_noise_coeff   <= noise;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent++;
   endtask

   // Random register setting: mostly a consistent q/t pair, plus the corners
   // (q all ones, tiny q, q of zero, delta of zero, unrelated registers).
   task automatic choose_setting(output tdc_pkg::word_type q, output tdc_pkg::word_type d,
                                 output tdc_pkg::word_type inc);
      int                w;
      int                tw;
      tdc_pkg::word_type t;
      w  = $urandom_range(2, 64);
      q  = (rand_word() >> (64 - w)) | (64'd1 << (w - 1));
      tw = $urandom_range(1, w);
      t  = rand_word() >> (64 - tw);
      if (t == '0) t = 64'd1;
      if (t > q) t = q;
      derive(q, t, d, inc);
      case ($urandom_range(0, 15))
         0: begin
            q = '1;
            derive(q, t, d, inc);
         end
         1: begin
            q = 64'($urandom_range(2, 16));
            derive(q, 64'($urandom_range(1, int'(q))), d, inc);
         end
         2: begin
            q   = '0;
            d   = 64'($urandom_range(0, 1000));
            inc = rand_word();
         end
         3: d = '0;
         4: begin
            q   = rand_word();
            d   = rand_word() >> $urandom_range(0, 63);
            inc = rand_word();
         end
         default: ;
      endcase
   endtask

   initial begin
      tdc_pkg::word_type q_v;
      tdc_pkg::word_type d_v;
      tdc_pkg::word_type inc_v;
      tdc_pkg::word_type thr;
      int                n;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // reset settings: q = 2, delta = 1, no increment
      send_coeffs('0, '0, '0, '0);
      send_coeffs(64'd1, '0, '0, '0);
      send_coeffs(64'd1, 64'd1, 64'd1, 64'd1);
      send_coeffs('1, '1, '1, '1);

      // realistic 64-bit modulus with t = 65537
      q_v = 64'hFFFF_FFFF_0000_0001;
      derive(q_v, 64'd65537, d_v, inc_v);
      write_regs(q_v, d_v, inc_v);
      thr = (q_v >> 1) + tdc_pkg::word_type'(q_v[0]);
      send_coeffs('0, '0, '0, '0);
      send_coeffs(q_v - 1, q_v - 1, q_v - 1, q_v - 1);
      send_coeffs(q_v - 1, 64'd1, '0, '0);               // wraps to zero
      send_coeffs(thr - (d_v >> 1) - 1, '0, '0, '0);     // just below ceil(q/2)
      send_coeffs(thr - (d_v >> 1), '0, '0, '0);         // exactly ceil(q/2)
      send_coeffs(d_v * 7, '0, '0, q_v - 3);             // negative noise
      send_coeffs('1, '1, '1, '1);                       // unreduced operands

      // q = all ones: the 65-bit sums carry out
      q_v = '1;
      derive(q_v, 64'd2, d_v, inc_v);
      write_regs(q_v, d_v, inc_v);
      send_coeffs(q_v - 1, q_v - 1, q_v - 1, q_v - 1);
      send_coeffs(q_v >> 1, '0, '0, '0);

      // modulus of zero: additions wrap mod 2^64, threshold zero
      write_regs('0, 64'd5, 64'd3);
      send_coeffs(rand_word(), rand_word(), rand_word(), rand_word());
      send_coeffs('1, 64'd1, '0, '0);

      // delta of zero: divider answers all ones
      write_regs(64'd1000, '0, 64'd7);
      send_coeffs(64'd1, 64'd2, 64'd3, 64'd4);
      send_coeffs(64'd999, '0, '0, '0);

      // increment larger than the value: the subtraction wraps
      write_regs(64'd100, 64'd10, '1);
      send_coeffs(64'd45, '0, '0, '0);
      send_coeffs(64'd10, '0, '0, '0);

      // every register all ones
      write_regs('1, '1, '1);
      send_coeffs('1, '0, '0, '0);
      send_coeffs(64'd5, 64'd6, 64'd7, 64'd8);

      // --- random part: phases of random settings, random residues ---
      while (sent < TotalItems) begin
         choose_setting(q_v, d_v, inc_v);
         write_regs(q_v, d_v, inc_v);
         n = $urandom_range(60, 140);
         repeat (n) begin
            send_coeffs(pick_field(cur_q), pick_field(cur_q),
                        pick_field(cur_q), pick_field(cur_q));
         end
      end

      drain();
      repeat (80) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
